/* rtl/pgr_pkg.sv */
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants for the proportional glyph renderer.
// ----------------------------------------------------------------------------
package pgr_pkg;

    // input word command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_PEN   = 2'd1;
    localparam logic [1:0] CMD_DRAW  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR_OFFSET = 2'd2;
    localparam logic [1:0] REG_FONT_LENGTH  = 2'd3;

    // glyph code range
    localparam logic [7:0] FIRST_GLYPH = 8'd33;
    localparam logic [7:0] LAST_GLYPH  = 8'd127;

    // register reset values
    localparam logic [3:0] SIDE_RESET   = 4'd8;
    localparam logic [7:0] OFFSET_RESET = 8'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_BASE,
        S_WALK,
        S_ONE
    } t_state;

endpackage

/* rtl/proportional_glyph_renderer_core.sv */
// ----------------------------------------------------------------------------
// proportional_glyph_renderer_core
// Bitmap font character generator with proportional pen advance.
// ----------------------------------------------------------------------------
// Three kinds of input word: a font byte write, a pen position set and a
// character draw. Writes and pen sets give no output.
// A draw of a code in 33..127 walks its glyph cell row by row from font
// address width*height*(code-33) and emits one pixel word per cell pixel;
// the pen x then moves by the largest lit column. Any other code emits a
// single unlit word and moves the pen by half the cell width. A glyph
// draw passes from its accept through two setup states (cell size, then
// the base-address multiply) and a registered font read, then emits one
// pixel word per cycle while the output side does not stall, set by the
// single read port of the font memory that the pixel walk steps through.
// A non-glyph draw passes through the setup state to the single-word
// state. Output stalls stretch the walk. No new word is taken until the
// draw is done. The font memory is not cleared; reading a byte that was
// never written gives an undefined color and lit flag.
// ----------------------------------------------------------------------------
module proportional_glyph_renderer_core
    import pgr_pkg::*;
#(
    parameter int FONT_DEPTH     = 8192,
    parameter int MAX_GLYPH_SIDE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [13:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [12:0]        i_font_addr,
    input  logic [7:0]         i_font_byte,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic [7:0]         i_char_code,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic [7:0]         o_pixel_color,
    output logic               o_lit,
    output logic signed [15:0] o_pen_after,
    output logic               o_last
);

    // address compare width: covers FONT_DEPTH up to 65536 and font_length
    localparam int CMPW = 17;
    localparam int AW   = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    // side width holds a side value up to MAX_GLYPH_SIDE
    localparam int SW   = $clog2(MAX_GLYPH_SIDE + 1);
    // pixel count width holds up to MAX_GLYPH_SIDE squared
    localparam int NW   = $clog2(MAX_GLYPH_SIDE * MAX_GLYPH_SIDE + 1);
    localparam logic [3:0] MAX_SIDE4 = 4'(MAX_GLYPH_SIDE);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [3:0]  r_glyph_w;
    logic [3:0]  r_glyph_h;
    logic [7:0]  r_color_offset;
    logic [13:0] r_font_length;

    logic [15:0] r_pen_x;
    logic [15:0] r_pen_y;

    logic [7:0]    r_code;
    logic [NW-1:0] r_n;
    logic [12:0]   r_addr;      // glyph walk address, stepped once per issued read
    logic [NW-1:0] r_left;      // pixels still to read
    logic [SW-1:0] r_col;
    logic [SW-1:0] r_row;
    logic [SW-1:0] r_maxcol;

    // read stage: memory data plus the pixel tag that travels with it
    logic          r_rd_valid;
    logic [SW-1:0] r_rd_col;
    logic [SW-1:0] r_rd_row;
    logic          r_rd_inrange;
    logic          r_rd_last;
    logic [7:0]    r_rdata;

    // output register
    logic        r_out_valid;
    logic [15:0] r_pixel_x;
    logic [15:0] r_pixel_y;
    logic [7:0]  r_pixel_color;
    logic        r_lit;
    logic [15:0] r_pen_after;
    logic        r_last;

    logic [7:0] font_mem [FONT_DEPTH];

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [SW-1:0]   side_w, side_h;
    logic            is_glyph;
    logic            adv;
    logic            issue;
    logic            load_walk;
    logic            load_one;
    logic            in_acc;
    logic [CMPW-1:0] wr_addr_ext;
    logic [CMPW-1:0] rd_addr_ext;
    logic            rd_inrange;
    logic            px_lit;
    logic [SW-1:0]   cand_max;
    logic [6:0]      glyph_idx;
    logic [7:0]      code_off;

    function automatic logic [SW-1:0] clamp_side(input logic [3:0] v);
        logic [SW-1:0] r;
        if (v == 4'd0) begin
            r = SW'(1);
        end else if (v > MAX_SIDE4) begin
            r = SW'(MAX_GLYPH_SIDE);
        end else begin
            r = SW'(v);
        end
        return r;
    endfunction

    assign side_w   = clamp_side(r_glyph_w);
    assign side_h   = clamp_side(r_glyph_h);
    assign is_glyph = (r_code >= FIRST_GLYPH) && (r_code <= LAST_GLYPH);
    assign code_off = r_code - FIRST_GLYPH;
    assign glyph_idx = code_off[6:0];

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    // output register free or being emptied this cycle
    assign adv       = !r_out_valid || i_ready;
    assign issue     = (r_state == S_WALK) && adv && (r_left != '0);
    assign load_walk = (r_state == S_WALK) && adv && r_rd_valid;
    assign load_one  = (r_state == S_ONE) && adv;

    assign wr_addr_ext = CMPW'(i_font_addr);
    assign rd_addr_ext = CMPW'(r_addr);
    assign rd_inrange  = (rd_addr_ext < CMPW'(r_font_length)) &&
                         (rd_addr_ext < CMPW'(FONT_DEPTH));

    assign px_lit   = r_rd_inrange && (r_rdata != 8'd0);
    assign cand_max = (px_lit && (r_rd_col > r_maxcol)) ? r_rd_col : r_maxcol;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_DRAW)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = is_glyph ? S_BASE : S_ONE;
            end
            S_BASE: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (load_walk && r_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ONE: begin
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // configuration and pen
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_w      <= SIDE_RESET;
            r_glyph_h      <= SIDE_RESET;
            r_color_offset <= OFFSET_RESET;
            r_font_length  <= '0;
            r_pen_x        <= '0;
            r_pen_y        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GLYPH_WIDTH:  r_glyph_w      <= i_cfg_data[3:0];
                    REG_GLYPH_HEIGHT: r_glyph_h      <= i_cfg_data[3:0];
                    REG_COLOR_OFFSET: r_color_offset <= i_cfg_data[7:0];
                    REG_FONT_LENGTH:  r_font_length  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && (i_cmd == CMD_PEN)) begin
                r_pen_x <= i_start_x;
                r_pen_y <= i_start_y;
            end else if (load_walk && r_rd_last) begin
                r_pen_x <= r_pen_x + 16'(cand_max);
            end else if (load_one) begin
                r_pen_x <= r_pen_x + 16'(side_w >> 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // font memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_cmd == CMD_WRITE) && (wr_addr_ext < CMPW'(FONT_DEPTH))) begin
            font_mem[wr_addr_ext[AW-1:0]] <= i_font_byte;
        end
        if (issue) begin
            r_rdata <= font_mem[rd_addr_ext[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // glyph walk datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_cmd == CMD_DRAW)) begin
            r_code <= i_char_code;
        end
        if (r_state == S_SETUP) begin
            r_n <= NW'(side_w) * NW'(side_h);
        end
        if (r_state == S_BASE) begin
            r_addr   <= 13'(r_n) * 13'(glyph_idx);
            r_left   <= r_n;
            r_col    <= '0;
            r_row    <= '0;
            r_maxcol <= '0;
        end
        if (issue) begin
            r_rd_col     <= r_col;
            r_rd_row     <= r_row;
            r_rd_inrange <= rd_inrange;
            r_rd_last    <= (r_left == NW'(1));
            r_addr       <= r_addr + 13'd1;
            r_left       <= r_left - NW'(1);
            if (r_col == side_w - SW'(1)) begin
                r_col <= '0;
                r_row <= r_row + SW'(1);
            end else begin
                r_col <= r_col + SW'(1);
            end
        end
        if (load_walk) begin
            r_maxcol <= cand_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (r_state == S_BASE) begin
            r_rd_valid <= 1'b0;
        end else if (adv) begin
            r_rd_valid <= issue;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= load_walk || load_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_walk) begin
            r_pixel_x     <= r_pen_x + 16'(r_rd_col);
            r_pixel_y     <= r_pen_y + 16'(r_rd_row);
            r_pixel_color <= r_rd_inrange ? (r_rdata + r_color_offset) : 8'd0;
            r_lit         <= px_lit;
            r_pen_after   <= r_rd_last ? (r_pen_x + 16'(cand_max)) : 16'd0;
            r_last        <= r_rd_last;
        end else if (load_one) begin
            r_pixel_x     <= r_pen_x;
            r_pixel_y     <= r_pen_y;
            r_pixel_color <= 8'd0;
            r_lit         <= 1'b0;
            r_pen_after   <= r_pen_x + 16'(side_w >> 1);
            r_last        <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_pixel_color = r_pixel_color;
    assign o_lit         = r_lit;
    assign o_pen_after   = r_pen_after;
    assign o_last        = r_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_rd_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_WALK))
        else $error("read stage busy outside the glyph walk");

    a_pen_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_pen_after == 16'd0))
        else $error("pen_after nonzero on a word that is not last");

    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_DRAW)) |=> (r_state == S_SETUP))
        else $error("draw word did not start the sequencer");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left <= r_n))
        else $error("walk count exceeds cell size");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_walk && r_rd_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after last pixel");

endmodule

/* bench/proportional_glyph_renderer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_glyph_renderer_core_tb
// Self-checking bench for the proportional glyph renderer core.
// ----------------------------------------------------------------------------
// A pixel tracker mirrors the font memory, the pen and the four registers.
// It turns every accepted input word into the pixel words the core must
// emit. Each output word is checked field by field in order. The stimulus
// is a font preload, a short directed pass over the corner cases, and then
// random phases with their own register settings. Both channels stall in
// random bursts; one phase blocks the output for a long stretch, and the
// last phase runs with no stalls at all.
// ----------------------------------------------------------------------------
module proportional_glyph_renderer_core_tb;
    import pgr_pkg::*;

    localparam int FONT_WORDS  = 8192;
    localparam int MAX_SIDE    = 8;
    localparam int PRELOAD     = 64;    // one 8x8 glyph; random lengths stay inside
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 13;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 12;    // covers a trailing write or pen set
    localparam int TAIL        = 60;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] addr;
        logic [7:0]  fbyte;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [7:0]  code;
    } t_word;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  color;
        logic        lit;
        logic [15:0] pen_after;
        logic        last;
    } t_pixel;

    // ------------------------------------------------------------------------
    // Pixel tracker: shadow of the core state plus the queue of pixel words
    // still owed by the core.
    // ------------------------------------------------------------------------
    class pixel_tracker;
        logic [7:0]  font_mem [FONT_WORDS];
        bit          loaded   [FONT_WORDS];
        logic [15:0] pen_x;
        logic [15:0] pen_y;
        logic [3:0]  width_reg;
        logic [3:0]  height_reg;
        logic [7:0]  color_offset;
        logic [13:0] font_length;
        t_pixel      pixels_due[$];
        int          errors;

        function new();
            pen_x        = '0;
            pen_y        = '0;
            width_reg    = SIDE_RESET;
            height_reg   = SIDE_RESET;
            color_offset = OFFSET_RESET;
            font_length  = '0;
            errors       = 0;
        endfunction

        // zero counts as one, anything past the cell limit as the limit
        function int side(logic [3:0] v);
            if (v == 4'd0) return 1;
            if (v > MAX_SIDE) return MAX_SIDE;
            return int'(v);
        endfunction

        function void set_reg(logic [1:0] idx, logic [13:0] val);
            case (idx)
                REG_GLYPH_WIDTH:  width_reg    = val[3:0];
                REG_GLYPH_HEIGHT: height_reg   = val[3:0];
                REG_COLOR_OFFSET: color_offset = val[7:0];
                REG_FONT_LENGTH:  font_length  = val;
                default: ;
            endcase
        endfunction

        // first byte a draw of this code would read that was never written,
        // or -1 when the draw is safe
        function int missing_byte(logic [7:0] code);
            int n, base, k;
            if (code < FIRST_GLYPH || code > LAST_GLYPH) return -1;
            n    = side(width_reg) * side(height_reg);
            base = n * (int'(code) - int'(FIRST_GLYPH));
            for (k = 0; k < n; k++) begin
                if (base + k < int'(font_length) && base + k < FONT_WORDS &&
                        !loaded[base + k])
                    return base + k;
            end
            return -1;
        endfunction

        function void note_word(t_word wd);
            int         gw, gh, n, base, a, k, maxcol;
            logic [7:0] b;
            t_pixel     px;
            case (wd.cmd)
                CMD_WRITE: begin
                    font_mem[wd.addr] = wd.fbyte;
                    loaded[wd.addr]   = 1'b1;
                end
                CMD_PEN: begin
                    pen_x = wd.sx;
                    pen_y = wd.sy;
                end
                CMD_DRAW: begin
                    gw = side(width_reg);
                    gh = side(height_reg);
                    n  = gw * gh;
                    if (wd.code < FIRST_GLYPH || wd.code > LAST_GLYPH) begin
                        // no glyph: one blank word, pen moves half a cell
                        px.x         = pen_x;
                        px.y         = pen_y;
                        px.color     = '0;
                        px.lit       = 1'b0;
                        px.pen_after = pen_x + 16'(gw / 2);
                        px.last      = 1'b1;
                        pixels_due.push_back(px);
                        pen_x = px.pen_after;
                    end else begin
                        base   = n * (int'(wd.code) - int'(FIRST_GLYPH));
                        maxcol = 0;
                        for (k = 0; k < n; k++) begin
                            a            = base + k;
                            px.x         = pen_x + 16'(k % gw);
                            px.y         = pen_y + 16'(k / gw);
                            px.color     = '0;
                            px.lit       = 1'b0;
                            px.pen_after = '0;
                            px.last      = 1'b0;
                            // bytes past the loaded length are skipped
                            if (a < int'(font_length) && a < FONT_WORDS) begin
                                b        = font_mem[a];
                                px.color = b + color_offset;
                                if (b != 8'd0) begin
                                    px.lit = 1'b1;
                                    if (k % gw > maxcol) maxcol = k % gw;
                                end
                            end
                            if (k == n - 1) begin
                                px.pen_after = pen_x + 16'(maxcol);
                                px.last      = 1'b1;
                            end
                            pixels_due.push_back(px);
                        end
                        pen_x = pen_x + 16'(maxcol);
                    end
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, name, want, got);
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: pixel word with none expected, x=%h y=%h",
                         $time, got.x, got.y);
                return;
            end
            want = pixels_due.pop_front();
            cmp_field("pixel_x", want.x, got.x);
            cmp_field("pixel_y", want.y, got.y);
            cmp_field("pixel_color", 16'(want.color), 16'(got.color));
            cmp_field("lit", 16'(want.lit), 16'(got.lit));
            cmp_field("pen_after", want.pen_after, got.pen_after);
            cmp_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [13:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_cmd;
    logic [12:0]        i_font_addr;
    logic [7:0]         i_font_byte;
    logic signed [15:0] i_start_x;
    logic signed [15:0] i_start_y;
    logic [7:0]         i_char_code;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_pixel_x;
    logic signed [15:0] o_pixel_y;
    logic [7:0]         o_pixel_color;
    logic               o_lit;
    logic signed [15:0] o_pen_after;
    logic               o_last;

    proportional_glyph_renderer_core #(
        .FONT_DEPTH    (FONT_WORDS),
        .MAX_GLYPH_SIDE(MAX_SIDE)
    ) u_dut (.*);

    pixel_tracker tracker = new();

    bit quiet     = 1'b0;   // no stalls on either side
    bit long_hold = 1'b0;   // ask the receiver for one long block

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // every word taken by the receiver is checked against the tracker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_pixel(t_pixel'{o_pixel_x, o_pixel_y, o_pixel_color,
                                         o_lit, o_pen_after, o_last});
    end

    // receiver: random stall bursts, plus one long block
    // counted here while the sender keeps pushing
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = LONG_HOLD - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offers one word, with an optional idle burst ahead of it, and holds it
    // until the core takes it. Valid stays high into the next word.
    task automatic send_word(t_word wd);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_cmd       <= wd.cmd;
        i_font_addr <= wd.addr;
        i_font_byte <= wd.fbyte;
        i_start_x   <= wd.sx;
        i_start_y   <= wd.sy;
        i_char_code <= wd.code;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_word(wd);
    endtask

    // unused fields carry random bits
    function automatic t_word any_word();
        t_word wd;
        wd.cmd   = 2'($urandom);
        wd.addr  = 13'($urandom);
        wd.fbyte = 8'($urandom);
        wd.sx    = 16'($urandom);
        wd.sy    = 16'($urandom);
        wd.code  = 8'($urandom);
        return wd;
    endfunction

    // a third of the font bytes are transparent
    function automatic logic [7:0] font_value();
        return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    function automatic logic [15:0] pen_coord();
        if ($urandom_range(0, 3) == 0) return 16'h7FF9 + 16'($urandom_range(0, 13));
        return 16'($urandom);
    endfunction

    function automatic logic [3:0] rand_side();
        if ($urandom_range(0, 9) < 7) return 4'($urandom_range(1, 8));
        return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    endfunction

    // random lengths stay within the preloaded bytes
    function automatic logic [13:0] rand_length();
        case ($urandom_range(0, 2))
            0:       return 14'd0;
            1:       return 14'(PRELOAD);
            default: return 14'($urandom_range(1, PRELOAD));
        endcase
    endfunction

    task automatic put_byte(int addr, logic [7:0] value);
        t_word wd;
        wd       = any_word();
        wd.cmd   = CMD_WRITE;
        wd.addr  = 13'(addr);
        wd.fbyte = value;
        send_word(wd);
    endtask

    task automatic set_pen(logic [15:0] x, logic [15:0] y);
        t_word wd;
        wd     = any_word();
        wd.cmd = CMD_PEN;
        wd.sx  = x;
        wd.sy  = y;
        send_word(wd);
    endtask

    // loads whatever part of the cell is still blank, then draws
    task automatic draw(logic [7:0] code);
        int    a;
        t_word wd;
        a = tracker.missing_byte(code);
        while (a >= 0) begin
            put_byte(a, font_value());
            a = tracker.missing_byte(code);
        end
        wd      = any_word();
        wd.cmd  = CMD_DRAW;
        wd.code = code;
        send_word(wd);
    endtask

    task automatic stray_word();
        t_word wd;
        wd     = any_word();
        wd.cmd = CMD_UNUSED;
        send_word(wd);
    endtask

    // sender goes idle until every owed pixel word is back and the core
    // has had time to finish any write or pen set behind it
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [13:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tracker.set_reg(idx, val);
    endtask

    // upper data bits of the narrow registers are junk on purpose
    task automatic configure(logic [3:0] gw, logic [3:0] gh, logic [7:0] off,
                             logic [13:0] len);
        settle();
        set_reg(REG_GLYPH_WIDTH, {10'($urandom), gw});
        set_reg(REG_GLYPH_HEIGHT, {10'($urandom), gh});
        set_reg(REG_COLOR_OFFSET, {6'($urandom), off});
        set_reg(REG_FONT_LENGTH, len);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one random word of the main mix, mostly draws of loaded glyphs
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            case ($urandom_range(0, 9))
                0, 1:    draw($urandom_range(0, 1) ? 8'($urandom_range(0, 32))
                                                   : 8'($urandom_range(128, 255)));
                8, 9:    draw(8'($urandom_range(33, 127)));
                default: draw(8'(33 + $urandom_range(0, 11)));
            endcase
        end else if (pick < 14) begin
            set_pen(pen_coord(), pen_coord());
        end else begin
            put_byte($urandom_range(0, FONT_WORDS - 1), font_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int phase;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_cmd       = '0;
        i_font_addr = '0;
        i_font_byte = '0;
        i_start_x   = '0;
        i_start_y   = '0;
        i_char_code = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // font preload while the loaded length is still zero
        for (sent = 0; sent < PRELOAD; sent++)
            put_byte(sent, font_value());

        // full cell, length cuts glyph 33 in two
        configure(4'd8, 4'd8, 8'd20, 14'd40);
        set_pen(16'h0000, 16'h0000);
        draw(8'd33);
        put_byte(0, 8'd0);
        draw(8'd33);
        draw(8'd34);            // wholly past the loaded length
        draw(8'd0);
        draw(8'd32);
        draw(8'd128);
        draw(8'd255);
        stray_word();
        set_pen(16'h7FFF, 16'h7FFF);
        draw(8'd33);            // x and y wrap inside the cell

        // zero width, oversize height, offset wraps every nonzero colour
        configure(4'd0, 4'd15, 8'd255, 14'h3FFF);
        set_pen(16'h8000, 16'hFFFF);
        draw(8'd127);
        draw(8'd33);
        draw(8'd31);            // half of a one-wide cell: no advance

        // oversize width, zero height, top of the font memory
        configure(4'd15, 4'd0, 8'd0, 14'd8192);
        put_byte(FONT_WORDS - 1, 8'hFF);
        draw(8'd40);
        draw(8'd127);
        set_pen(16'hFFFF, 16'h0000);
        draw(8'd200);           // pen wraps past zero

        // nothing loaded: every pixel skipped
        configure(4'd8, 4'd8, 8'($urandom), 14'd0);
        draw(8'd35);

        // random phases
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) begin
                quiet = 1'b1;
                configure(4'd8, 4'd8, 8'($urandom), 14'(PRELOAD));
            end else if (phase == 2) begin
                configure(4'd8, 4'd8, 8'($urandom), rand_length());
                long_hold = 1'b1;
            end else begin
                configure(rand_side(), rand_side(), 8'($urandom), rand_length());
            end
            sent = 0;
            while (sent < PHASE_WORDS) begin
                // mid-phase pause until the output side has caught up
                if (phase == 3 && sent == PHASE_WORDS / 2)
                    settle();
                if ($urandom_range(0, 9) == 0) begin
                    stray_word();
                end else begin
                    random_word();
                    sent++;
                end
            end
        end

        settle();
        repeat (TAIL) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pixels_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
